// ===== rtl/pia_pkg.sv =====
package pia_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PINS  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  // delays in ticks
  localparam logic [4:0] IRQ_DELAY_TICKS     = 5'd14;
  localparam logic [5:0] READ_STROBE_TICKS   = 6'd8;
  localparam logic [5:0] READ_RESTORE_TICKS  = 6'd24;
  localparam logic [5:0] WRITE_STROBE_TICKS  = 6'd16;
  localparam logic [5:0] WRITE_RESTORE_TICKS = 6'd48;

  typedef struct packed {
    op_t        operation;
    logic [1:0] reg_select;
    logic [7:0] write_data;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
    logic       ca1_level;
    logic       ca2_level;
    logic       cb1_level;
    logic       cb2_level;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] port_a_drive;
    logic [7:0] port_b_source;
    logic [7:0] port_b_sink;
    logic       ca2_drive;
    logic       cb2_source;
    logic       cb2_sink;
    logic       irq_a;
    logic       irq_b;
  } result_t;

  // next-state view of one side, as seen by the result register
  typedef struct packed {
    logic [7:0] rd;
    logic [7:0] out_bits;
    logic [7:0] dir_bits;
    logic       c2_src;
    logic       c2_snk;
    logic       irq;
  } side_next_t;

endpackage

// ===== rtl/pia_side.sv =====
module pia_side
  import pia_pkg::*;
#(
  parameter logic [4:0] IRQ_DELAY     = IRQ_DELAY_TICKS,
  parameter logic [5:0] READ_STROBE   = READ_STROBE_TICKS,
  parameter logic [5:0] READ_RESTORE  = READ_RESTORE_TICKS,
  parameter logic [5:0] WRITE_STROBE  = WRITE_STROBE_TICKS,
  parameter logic [5:0] WRITE_RESTORE = WRITE_RESTORE_TICKS
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       side_b,
  input  logic       en,
  input  item_t      item,
  input  logic       c1_level,
  input  logic       c2_level,
  output side_next_t nxt
);

  logic [5:0] cr, cr_next;
  logic [7:0] dir, dir_next;
  logic [7:0] outb, outb_next;
  logic       c1_last, c1_last_next;
  logic       c2_last, c2_last_next;
  logic       flag_one, flag_one_next;
  logic       flag_two, flag_two_next;
  logic       irq, irq_next;
  logic       src, src_next;
  logic       snk, snk_next;
  logic [4:0] irq_tmr, irq_tmr_next;
  logic [5:0] stb_tmr, stb_tmr_next;
  logic [5:0] rest_tmr, rest_tmr_next;
  logic [7:0] rd;
  logic       sel;
  logic       seen;
  logic       v;

  always_comb begin
    cr_next       = cr;
    dir_next      = dir;
    outb_next     = outb;
    c1_last_next  = c1_last;
    c2_last_next  = c2_last;
    flag_one_next = flag_one;
    flag_two_next = flag_two;
    irq_next      = irq;
    src_next      = src;
    snk_next      = snk;
    irq_tmr_next  = irq_tmr;
    stb_tmr_next  = stb_tmr;
    rest_tmr_next = rest_tmr;
    rd            = 8'd0;
    v             = 1'b1;
    sel           = (item.reg_select[1] == side_b);

    // C1 edge
    if (c1_level != c1_last) begin
      c1_last_next = c1_level;
      if (cr[1] == c1_level) begin
        if (cr[5:3] == 3'b101) begin
          src_next = 1'b1;
          snk_next = 1'b1;
        end
        flag_one_next = 1'b1;
        if (cr[0]) begin
          if (irq_tmr_next == 5'd0) irq_tmr_next = IRQ_DELAY;
        end else begin
          irq_next = 1'b0;
        end
      end
    end

    // C2 edge, on the level after our own sink/source
    seen = side_b ? ((src_next | c2_level) & snk_next) : (c2_level & snk_next);
    if (cr[5]) begin
      flag_two_next = 1'b0;
    end else if (seen != c2_last_next) begin
      c2_last_next = seen;
      if (cr[4] == seen) begin
        flag_two_next = 1'b1;
        if (cr[3]) begin
          if (irq_tmr_next == 5'd0) irq_tmr_next = IRQ_DELAY;
        end else begin
          irq_next = 1'b0;
        end
      end
    end

    unique case (item.operation)
      OP_READ: begin
        if (sel) begin
          if (item.reg_select[0]) begin
            rd = {flag_one_next, flag_two_next, cr};
          end else if (!cr[2]) begin
            rd = dir;
          end else begin
            flag_one_next = 1'b0;
            flag_two_next = 1'b0;
            irq_next      = 1'b0;
            if (!side_b) begin
              if (cr[5:4] == 2'b10) begin
                stb_tmr_next  = READ_STROBE;
                rest_tmr_next = cr[3] ? READ_RESTORE : 6'd0;
              end
              rd = ~(~outb & dir) & item.port_a_pins;
            end else begin
              rd = (outb & dir) | (item.port_b_pins & ~dir);
            end
          end
        end
      end
      OP_WRITE: begin
        if (sel) begin
          if (item.reg_select[0]) begin
            cr_next = item.write_data[5:0];
            if (item.write_data[5]) flag_two_next = 1'b0;
            if (item.write_data[0]) begin
              irq_next = irq_next | flag_one_next;
            end else if (!item.write_data[5] && item.write_data[3]) begin
              irq_next = irq_next | flag_two_next;
            end else begin
              irq_next = 1'b0;
            end
            if (item.write_data[5]) begin
              v = item.write_data[4] ? item.write_data[3] : 1'b1;
              if (side_b) src_next = v;
              snk_next = v;
            end else begin
              if (side_b) src_next = 1'b0;
              snk_next = 1'b1;
              // released line: seen level is the raw pin
              if (c2_level != c2_last_next) begin
                c2_last_next = c2_level;
                if (item.write_data[4] == c2_level) begin
                  flag_two_next = 1'b1;
                  if (item.write_data[3]) begin
                    if (irq_tmr_next == 5'd0) irq_tmr_next = IRQ_DELAY;
                  end else begin
                    irq_next = 1'b0;
                  end
                end
              end
            end
          end else if (!cr[2]) begin
            dir_next = item.write_data;
          end else begin
            outb_next = item.write_data;
            if (side_b && cr[5:4] == 2'b10) begin
              stb_tmr_next  = WRITE_STROBE;
              rest_tmr_next = cr[3] ? WRITE_RESTORE : 6'd0;
            end
          end
        end
      end
      OP_TICK: begin
        if (irq_tmr_next != 5'd0) begin
          irq_tmr_next = irq_tmr_next - 5'd1;
          if (irq_tmr_next == 5'd0) irq_next = 1'b1;
        end
        // strobe first, restore second: coinciding expiry ends released
        if (stb_tmr_next != 6'd0) begin
          stb_tmr_next = stb_tmr_next - 6'd1;
          if (stb_tmr_next == 6'd0) begin
            src_next = 1'b0;
            snk_next = 1'b0;
          end
        end
        if (rest_tmr_next != 6'd0) begin
          rest_tmr_next = rest_tmr_next - 6'd1;
          if (rest_tmr_next == 6'd0) begin
            src_next = 1'b1;
            snk_next = 1'b1;
          end
        end
      end
      OP_PINS: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cr       <= 6'd0;
      dir      <= 8'd0;
      outb     <= 8'd0;
      c1_last  <= 1'b0;
      c2_last  <= 1'b0;
      flag_one <= 1'b0;
      flag_two <= 1'b0;
      irq      <= 1'b0;
      src      <= 1'b0;
      snk      <= 1'b1;
      irq_tmr  <= 5'd0;
      stb_tmr  <= 6'd0;
      rest_tmr <= 6'd0;
    end else if (en) begin
      cr       <= cr_next;
      dir      <= dir_next;
      outb     <= outb_next;
      c1_last  <= c1_last_next;
      c2_last  <= c2_last_next;
      flag_one <= flag_one_next;
      flag_two <= flag_two_next;
      irq      <= irq_next;
      src      <= src_next;
      snk      <= snk_next;
      irq_tmr  <= irq_tmr_next;
      stb_tmr  <= stb_tmr_next;
      rest_tmr <= rest_tmr_next;
    end
  end

  assign nxt.rd       = rd;
  assign nxt.out_bits = outb_next;
  assign nxt.dir_bits = dir_next;
  assign nxt.c2_src   = src_next;
  assign nxt.c2_snk   = snk_next;
  assign nxt.irq      = irq_next;

endmodule

// ===== rtl/parallel_interface_adapter.sv =====
// An accepted item is held in the input register and its result in the result
// register; a stalled result holds the following item in the input register.
// Throughput: one item per cycle while the result is not stalled; the side
// state loop closes through the per-side next-state logic.
// Reset: synchronous, active high; clears both sides (C2 sinks released),
// empties the input and result registers.
module parallel_interface_adapter
  import pia_pkg::*;
#(
  parameter logic [4:0] IRQ_DELAY     = IRQ_DELAY_TICKS,
  parameter logic [5:0] READ_STROBE   = READ_STROBE_TICKS,
  parameter logic [5:0] READ_RESTORE  = READ_RESTORE_TICKS,
  parameter logic [5:0] WRITE_STROBE  = WRITE_STROBE_TICKS,
  parameter logic [5:0] WRITE_RESTORE = WRITE_RESTORE_TICKS
)
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic       item_full;
  item_t      item_q;
  logic       advance;
  side_next_t nxt_a;
  side_next_t nxt_b;
  result_t    result_next;

  assign advance    = item_full && (!result_valid || !result_stall);
  assign item_stall = item_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) item_q <= item;
  end

  pia_side #(
    .IRQ_DELAY     (IRQ_DELAY),
    .READ_STROBE   (READ_STROBE),
    .READ_RESTORE  (READ_RESTORE),
    .WRITE_STROBE  (WRITE_STROBE),
    .WRITE_RESTORE (WRITE_RESTORE)
  ) u_side_a (
    .clk      (clk),
    .rst      (rst),
    .side_b   (1'b0),
    .en       (advance),
    .item     (item_q),
    .c1_level (item_q.ca1_level),
    .c2_level (item_q.ca2_level),
    .nxt      (nxt_a)
  );

  pia_side #(
    .IRQ_DELAY     (IRQ_DELAY),
    .READ_STROBE   (READ_STROBE),
    .READ_RESTORE  (READ_RESTORE),
    .WRITE_STROBE  (WRITE_STROBE),
    .WRITE_RESTORE (WRITE_RESTORE)
  ) u_side_b (
    .clk      (clk),
    .rst      (rst),
    .side_b   (1'b1),
    .en       (advance),
    .item     (item_q),
    .c1_level (item_q.cb1_level),
    .c2_level (item_q.cb2_level),
    .nxt      (nxt_b)
  );

  always_comb begin
    result_next.read_data     = nxt_a.rd | nxt_b.rd;
    result_next.port_a_drive  = ~(~nxt_a.out_bits & nxt_a.dir_bits);
    result_next.port_b_source = nxt_b.out_bits & nxt_b.dir_bits;
    result_next.port_b_sink   = nxt_b.out_bits | ~nxt_b.dir_bits;
    result_next.ca2_drive     = nxt_a.c2_snk;
    result_next.cb2_source    = nxt_b.c2_src;
    result_next.cb2_sink      = nxt_b.c2_snk;
    result_next.irq_a         = nxt_a.irq;
    result_next.irq_b         = nxt_b.irq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result <= result_next;
  end

endmodule

// ===== rtl/pia_checker.sv =====
module pia_checker
  import pia_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // held result must not move
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  assert property (@(posedge clk) rst |=> !result_valid && !item_stall)
    else $error("not empty after reset");

  // input only backs up when the result side is blocked
  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled without a blocked result");

  // a port B bit driven high is never pulled low
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.port_b_source & ~result.port_b_sink) == 8'd0)
    else $error("port B source and sink conflict");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.cb2_source |-> result.cb2_sink)
    else $error("CB2 driven high while sunk");

endmodule

bind parallel_interface_adapter pia_checker u_pia_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
